// ===== src/hmpg_pkg.sv =====
// Shared types and constants for the haptic pattern generator.
// No dependencies; imported by every module of the block.
`default_nettype none

package hmpg_pkg;

   // field widths
   localparam int REQ_TYPE_W = 2;
   localparam int PAD_W      = 3;
   localparam int CODE_W     = 8;
   localparam int DUTY_W     = 8;
   localparam int TIME_W     = 32;
   localparam int LEN_W      = 16;
   localparam int HALF_W     = LEN_W - 1;
   localparam int PROD_W     = DUTY_W + HALF_W;
   localparam int PAT_W      = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // divider geometry
   localparam int DIV_W     = TIME_W;
   localparam int DSR_W     = LEN_W;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   // request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_TICK    = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_START   = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_STOP    = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_SERVICE = 2'd3;

   // stored pattern codes
   localparam logic [PAT_W-1:0] PAT_NONE  = 2'd0;
   localparam logic [PAT_W-1:0] PAT_PULSE = 2'd1;
   localparam logic [PAT_W-1:0] PAT_RAMP  = 2'd2;
   localparam logic [PAT_W-1:0] PAT_BURST = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_LEN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_DUTY  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BURST_CHNK = 2'd2;

   // register reset values
   localparam logic [LEN_W-1:0]  PULSE_LEN_RST   = 16'd600;
   localparam logic [DUTY_W-1:0] PEAK_DUTY_RST   = 8'd255;
   localparam logic [LEN_W-1:0]  BURST_CHUNK_RST = 16'd150;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_type;
      logic [PAD_W-1:0]      pad_index;
      logic [CODE_W-1:0]     pattern_code;
   } req_word_type;

   typedef struct packed {
      logic [PAD_W-1:0]  out_pad;
      logic [DUTY_W-1:0] duty;
      logic              last_of_run;
   } rsp_word_type;

   // request to the shared divider
   typedef struct packed {
      logic             go;
      logic [DIV_W-1:0] dividend;
      logic [DSR_W-1:0] divisor;
   } div_req_type;

   // divider status back to the sequencer
   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

// ===== src/hmpg_div.sv =====
// Shared radix-2 restoring divider, one quotient bit per cycle.
// Depends on hmpg_pkg for widths and request/response structs.
`default_nettype none

module hmpg_div
   import hmpg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DSR_W-1:0]     rem_ff, rem_in;
   logic [DSR_W-1:0]     dsr_ff, dsr_in;
   logic [DSR_W:0]       trial;
   logic                 fits;

   // one shift-and-subtract step
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (div_req.go) begin
         run_in = 1'b1;
         cnt_in = '0;
         quo_in = div_req.dividend;
         rem_in = '0;
         dsr_in = div_req.divisor;
      end else if (run_ff) begin
         rem_in = fits ? DSR_W'(trial - {1'b0, dsr_ff}) : DSR_W'(trial);
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

`default_nettype wire

// ===== src/multi_channel_haptic_pattern_generator_unit.sv =====
// Top level of the haptic pattern generator: pad state, sequencer, registers.
// Depends on hmpg_pkg and instantiates the shared divider hmpg_div.
`default_nettype none

// Tick, start and stop words are taken from idle; busy stays low and the
// next word may follow at once. Start and stop for a pad in range answer with
// one result word in the cycle after acceptance. A service word walks the
// pads one at a time: an inactive pad is only seen in the load state, an
// expired, pulse or flat ramp pad is answered from the eval state, and a ramp
// or burst pad that needs a quotient waits in the wait state for the shared
// one-bit-per-cycle divider. Busy is high for the whole walk. Result words
// show on rsp_word for exactly one cycle with rsp_valid high; the receiver
// cannot stall them, so it must take every word as it comes.
module multi_channel_haptic_pattern_generator_unit
   import hmpg_pkg::*;
#(
   parameter int NUM_PADS = 3
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire req_word_type          req_word,
   output logic                       rsp_valid,
   output rsp_word_type               rsp_word,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int PAD_IDX_W = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOAD = 2'd1;
   localparam logic [1:0] S_EVAL = 2'd2;
   localparam logic [1:0] S_WAIT = 2'd3;

   // what the pending quotient is for
   localparam logic [1:0] M_UP    = 2'd0;
   localparam logic [1:0] M_DOWN  = 2'd1;
   localparam logic [1:0] M_BURST = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [1:0]           mode_ff, mode_in;
   logic [PAD_IDX_W-1:0] scan_ff, scan_in;
   logic [TIME_W-1:0]    now_ff, now_in;
   logic [TIME_W-1:0]    elapsed_ff, elapsed_in;
   logic                 expired_ff, expired_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_word_type         rsp_word_ff, rsp_word_in;

   logic [LEN_W-1:0]     pulse_len_ff;
   logic [DUTY_W-1:0]    peak_ff;
   logic [LEN_W-1:0]     chunk_ff;

   logic [NUM_PADS-1:0]  active_ff;
   logic [PAT_W-1:0]     pattern_ff [NUM_PADS];
   logic [TIME_W-1:0]    start_ms_ff [NUM_PADS];
   logic [TIME_W-1:0]    end_ms_ff [NUM_PADS];

   // pad table write controls
   logic                 arm_en;
   logic [PAD_IDX_W-1:0] arm_idx;
   logic [PAT_W-1:0]     arm_pat;
   logic                 clr_en;
   logic [PAD_IDX_W-1:0] clr_idx;

   logic                 accept;
   logic                 pad_ok;
   logic [PAD_IDX_W-1:0] req_idx;
   logic [PAT_W-1:0]     req_pat;
   logic                 more_above;
   logic                 scan_last;
   logic [HALF_W-1:0]    half;
   logic [TIME_W-1:0]    down;
   logic [HALF_W-1:0]    ramp_x;
   logic [PROD_W-1:0]    ramp_prod;
   logic [LEN_W-1:0]     chunk_eff;
   logic [DUTY_W-1:0]    quo_duty;
   logic [TIME_W-1:0]    end_gap;

   div_req_type          div_req;
   div_rsp_type          div_rsp;

   hmpg_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign accept  = start && (state_ff == S_IDLE);
   assign pad_ok  = (int'(req_word.pad_index) < NUM_PADS);
   assign req_idx = req_word.pad_index[PAD_IDX_W-1:0];

   // pattern codes other than ramp and burst fall back to pulse
   assign req_pat = ((req_word.pattern_code == CODE_W'(PAT_RAMP)) ||
                     (req_word.pattern_code == CODE_W'(PAT_BURST)))
                    ? req_word.pattern_code[PAT_W-1:0] : PAT_PULSE;

   assign scan_last = (scan_ff == PAD_IDX_W'(NUM_PADS - 1));
   assign half      = pulse_len_ff[LEN_W-1:1];
   assign down      = elapsed_ff - {{(TIME_W-HALF_W){1'b0}}, half};
   assign chunk_eff = (chunk_ff == '0) ? LEN_W'(1) : chunk_ff;
   assign end_gap   = now_ff - end_ms_ff[scan_ff];

   // single ramp multiplier: the ramp position operand is below half on every use
   assign ramp_x    = (elapsed_ff < {{(TIME_W-HALF_W){1'b0}}, half})
                      ? elapsed_ff[HALF_W-1:0] : down[HALF_W-1:0];
   assign ramp_prod = PROD_W'(peak_ff) * PROD_W'(ramp_x);

   // quotient to duty
   always_comb begin
      unique case (mode_ff)
         M_UP:    quo_duty = div_rsp.quotient[DUTY_W-1:0];
         M_DOWN:  quo_duty = peak_ff - div_rsp.quotient[DUTY_W-1:0];
         default: quo_duty = div_rsp.quotient[0] ? '0 : peak_ff;
      endcase
   end

   // any active pad after the current one decides last_of_run
   always_comb begin
      more_above = 1'b0;
      for (int i = 0; i < NUM_PADS; i++) begin
         if ((i > int'(scan_ff)) && active_ff[i]) begin
            more_above = 1'b1;
         end
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      scan_in      = scan_ff;
      now_in       = now_ff;
      elapsed_in   = elapsed_ff;
      expired_in   = expired_ff;
      rsp_valid_in = 1'b0;
      rsp_word_in  = rsp_word_ff;
      arm_en       = 1'b0;
      arm_idx      = req_idx;
      arm_pat      = req_pat;
      clr_en       = 1'b0;
      clr_idx      = req_idx;
      div_req      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_word.req_type)
                  REQ_TICK: begin
                     now_in = now_ff + TIME_W'(1);
                  end
                  REQ_START: begin
                     if (pad_ok) begin
                        arm_en       = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_word_in  = '{out_pad: req_word.pad_index,
                                         duty: peak_ff, last_of_run: 1'b1};
                     end
                  end
                  REQ_STOP: begin
                     if (pad_ok) begin
                        clr_en       = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_word_in  = '{out_pad: req_word.pad_index,
                                         duty: '0, last_of_run: 1'b1};
                     end
                  end
                  default: begin
                     scan_in  = '0;
                     state_in = S_LOAD;
                  end
               endcase
            end
         end
         S_LOAD: begin
            if (active_ff[scan_ff]) begin
               elapsed_in = now_ff - start_ms_ff[scan_ff];
               expired_in = !end_gap[TIME_W-1];
               state_in   = S_EVAL;
            end else if (scan_last) begin
               state_in = S_IDLE;
            end else begin
               scan_in = scan_ff + PAD_IDX_W'(1);
            end
         end
         S_EVAL: begin
            rsp_word_in.out_pad     = PAD_W'(scan_ff);
            rsp_word_in.last_of_run = !more_above;
            rsp_word_in.duty        = peak_ff;
            priority if (expired_ff) begin
               clr_en           = 1'b1;
               clr_idx          = scan_ff;
               rsp_valid_in     = 1'b1;
               rsp_word_in.duty = '0;
            end else if ((pattern_ff[scan_ff] == PAT_RAMP) && (half != '0)) begin
               if (elapsed_ff < {{(TIME_W-HALF_W){1'b0}}, half}) begin
                  div_req  = '{go: 1'b1, dividend: DIV_W'(ramp_prod),
                               divisor: DSR_W'(half)};
                  mode_in  = M_UP;
                  state_in = S_WAIT;
               end else if (down >= {{(TIME_W-HALF_W){1'b0}}, half}) begin
                  rsp_valid_in     = 1'b1;
                  rsp_word_in.duty = '0;
               end else begin
                  div_req  = '{go: 1'b1, dividend: DIV_W'(ramp_prod),
                               divisor: DSR_W'(half)};
                  mode_in  = M_DOWN;
                  state_in = S_WAIT;
               end
            end else if (pattern_ff[scan_ff] == PAT_BURST) begin
               div_req  = '{go: 1'b1, dividend: elapsed_ff, divisor: chunk_eff};
               mode_in  = M_BURST;
               state_in = S_WAIT;
            end else begin
               // pulse, or ramp with zero half length
               rsp_valid_in = 1'b1;
            end
            if (rsp_valid_in) begin
               if (scan_last) begin
                  state_in = S_IDLE;
               end else begin
                  scan_in  = scan_ff + PAD_IDX_W'(1);
                  state_in = S_LOAD;
               end
            end
         end
         default: begin
            if (div_rsp.done) begin
               rsp_valid_in     = 1'b1;
               rsp_word_in.duty = quo_duty;
               if (scan_last) begin
                  state_in = S_IDLE;
               end else begin
                  scan_in  = scan_ff + PAD_IDX_W'(1);
                  state_in = S_LOAD;
               end
            end
         end
      endcase
   end

   // control and time registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         scan_ff      <= '0;
         now_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         pulse_len_ff <= PULSE_LEN_RST;
         peak_ff      <= PEAK_DUTY_RST;
         chunk_ff     <= BURST_CHUNK_RST;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         now_ff       <= now_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_PULSE_LEN:  pulse_len_ff <= csr_wdata[LEN_W-1:0];
               CSR_PEAK_DUTY:  peak_ff      <= csr_wdata[DUTY_W-1:0];
               CSR_BURST_CHNK: chunk_ff     <= csr_wdata[LEN_W-1:0];
               default: ;
            endcase
         end
      end
      mode_ff     <= mode_in;
      elapsed_ff  <= elapsed_in;
      expired_ff  <= expired_in;
      rsp_word_ff <= rsp_word_in;
   end

   // pad table
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else begin
         if (arm_en) begin
            active_ff[arm_idx] <= 1'b1;
         end
         if (clr_en) begin
            active_ff[clr_idx] <= 1'b0;
         end
      end
      if (arm_en) begin
         pattern_ff[arm_idx]  <= arm_pat;
         start_ms_ff[arm_idx] <= now_ff;
         end_ms_ff[arm_idx]   <= now_ff + {{(TIME_W-LEN_W){1'b0}}, pulse_len_ff};
      end
      if (clr_en) begin
         pattern_ff[clr_idx] <= PAT_NONE;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

// ===== verif/multi_channel_haptic_pattern_generator_unit_test.sv =====
// Self-checking testbench for the haptic pattern generator: directed and random
// command words, a scoreboard that predicts every duty update word.
// Depends on hmpg_pkg and multi_channel_haptic_pattern_generator_unit.
`timescale 1ns / 1ps

module multi_channel_haptic_pattern_generator_unit_test;
   import hmpg_pkg::*;

   localparam int NUM_PADS       = 3;
   // worst service walk plus margin
   localparam int SERVICE_CYCLES = 36 * NUM_PADS + 16;
   localparam int LIMIT_CYCLES   = 500000;
   localparam int RANDOM_WORDS   = 240;
   localparam int PHASES         = 6;

   // Scoreboard: own copy of pad state and registers, queue of expected duty words
   class haptic_scoreboard;
      logic [LEN_W-1:0]  pulse_len;
      logic [DUTY_W-1:0] peak;
      logic [LEN_W-1:0]  chunk;
      logic [TIME_W-1:0] now_ms;
      logic              pad_on  [NUM_PADS];
      logic [PAT_W-1:0]  pad_pat [NUM_PADS];
      logic [TIME_W-1:0] pad_t0  [NUM_PADS];
      logic [TIME_W-1:0] pad_t1  [NUM_PADS];
      rsp_word_type      duty_queue[$];
      int errors, checked;
      int n_tick, n_start, n_stop, n_service, n_ignored;

      function new();
         pulse_len = PULSE_LEN_RST;
         peak      = PEAK_DUTY_RST;
         chunk     = BURST_CHUNK_RST;
         now_ms    = '0;
         foreach (pad_on[i]) begin
            pad_on[i]  = 1'b0;
            pad_pat[i] = PAT_NONE;
            pad_t0[i]  = '0;
            pad_t1[i]  = '0;
         end
         errors = 0;
         checked = 0;
         n_tick = 0;
         n_start = 0;
         n_stop = 0;
         n_service = 0;
         n_ignored = 0;
      endfunction

      task report_mismatch(input string msg);
         errors++;
         if (errors <= 30) begin
            $display("MISMATCH @%0t: %s", $time, msg);
         end
      endtask

      function void write_reg(input logic [CSR_IDX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_PULSE_LEN:  pulse_len = data[LEN_W-1:0];
            CSR_PEAK_DUTY:  peak      = data[DUTY_W-1:0];
            CSR_BURST_CHNK: chunk     = data[LEN_W-1:0];
            default: ;
         endcase
      endfunction

      // duty of a running, unexpired pad
      function logic [DUTY_W-1:0] pattern_duty(input int p);
         logic [TIME_W-1:0] elapsed;
         longint unsigned el, pk, half, slice, drop;
         elapsed = now_ms - pad_t0[p];
         el      = elapsed;
         pk      = peak;
         half    = pulse_len >> 1;
         slice   = (chunk == 0) ? 1 : chunk;
         if (pad_pat[p] == PAT_RAMP) begin
            if (half == 0) return peak;
            if (el < half) return DUTY_W'((pk * el) / half);
            // falling edge, saturates at zero if the length shrank meanwhile
            drop = (pk * (el - half)) / half;
            if (drop >= pk) return '0;
            return DUTY_W'(pk - drop);
         end
         if (pad_pat[p] == PAT_BURST) begin
            return ((el / slice) % 2 == 0) ? peak : '0;
         end
         return peak;
      endfunction

      // accepted command word: update state, queue the words it causes
      function void note_request(input req_word_type w);
         rsp_word_type run[$];
         rsp_word_type r;
         int p;
         p = w.pad_index;
         r.last_of_run = 1'b0;
         case (w.req_type)
            REQ_TICK: begin
               now_ms = now_ms + 1;
               n_tick++;
            end
            REQ_START: begin
               if (p >= NUM_PADS) begin
                  n_ignored++;
               end else begin
                  n_start++;
                  pad_on[p] = 1'b1;
                  if (w.pattern_code == CODE_W'(PAT_RAMP) ||
                      w.pattern_code == CODE_W'(PAT_BURST)) begin
                     pad_pat[p] = w.pattern_code[PAT_W-1:0];
                  end else begin
                     pad_pat[p] = PAT_PULSE;
                  end
                  pad_t0[p] = now_ms;
                  pad_t1[p] = now_ms + TIME_W'(pulse_len);
                  r.out_pad = PAD_W'(p);
                  r.duty    = peak;
                  run.push_back(r);
               end
            end
            REQ_STOP: begin
               if (p >= NUM_PADS) begin
                  n_ignored++;
               end else begin
                  n_stop++;
                  pad_on[p]  = 1'b0;
                  pad_pat[p] = PAT_NONE;
                  r.out_pad  = PAD_W'(p);
                  r.duty     = '0;
                  run.push_back(r);
               end
            end
            default: begin
               n_service++;
               for (int i = 0; i < NUM_PADS; i++) begin
                  if (pad_on[i]) begin
                     r.out_pad = PAD_W'(i);
                     // expired once now has reached the end time (wrapping compare)
                     if (((now_ms - pad_t1[i]) & (TIME_W'(1) << (TIME_W - 1))) == '0) begin
                        r.duty     = '0;
                        pad_on[i]  = 1'b0;
                        pad_pat[i] = PAT_NONE;
                     end else begin
                        r.duty = pattern_duty(i);
                     end
                     run.push_back(r);
                  end
               end
            end
         endcase
         if (run.size() > 0) begin
            run[run.size() - 1].last_of_run = 1'b1;
            foreach (run[k]) duty_queue.push_back(run[k]);
         end
      endfunction

      task check_response(input rsp_word_type got);
         rsp_word_type want;
         if (duty_queue.size() == 0) begin
            report_mismatch($sformatf("unexpected word pad %0d duty %0d last %0b",
                                      got.out_pad, got.duty, got.last_of_run));
            return;
         end
         want = duty_queue.pop_front();
         checked++;
         if (got.out_pad !== want.out_pad)
            report_mismatch($sformatf("out_pad %0d, expected %0d", got.out_pad, want.out_pad));
         if (got.duty !== want.duty)
            report_mismatch($sformatf("duty %0d on pad %0d, expected %0d",
                                      got.duty, want.out_pad, want.duty));
         if (got.last_of_run !== want.last_of_run)
            report_mismatch($sformatf("last_of_run %0b on pad %0d, expected %0b",
                                      got.last_of_run, want.out_pad, want.last_of_run));
      endtask
   endclass

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic                  busy;
   req_word_type          req_word  = '0;
   logic                  rsp_valid;
   rsp_word_type          rsp_word;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   haptic_scoreboard sb;
   int burst_left = 0;
   int settings   = 0;

   multi_channel_haptic_pattern_generator_unit #(.NUM_PADS(NUM_PADS)) dut (
      .clock, .reset, .start, .busy, .req_word,
      .rsp_valid, .rsp_word, .csr_we, .csr_index, .csr_wdata
   );

   always #5 clock = ~clock;

   // sample every handshake at the edge that completes it
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) sb.write_reg(csr_index, csr_wdata);
         if (start && !busy) sb.note_request(req_word);
         if (rsp_valid) sb.check_response(rsp_word);
      end
   end

   function automatic req_word_type make_word(input logic [REQ_TYPE_W-1:0] t,
                                              input int pad, input int code);
      req_word_type w;
      w.req_type     = t;
      w.pad_index    = PAD_W'(pad);
      w.pattern_code = CODE_W'(code);
      return w;
   endfunction

   // hold a word on the port until the block takes it
   task automatic send_word(input req_word_type w);
      start    <= 1'b1;
      req_word <= w;
      do begin
         @(posedge clock);
      end while (busy);
   endtask

   // gap with junk on the idle word port
   task automatic idle(input int n);
      logic [$bits(req_word_type)-1:0] junk;
      if (n > 0) begin
         junk = $bits(req_word_type)'($urandom);
         start    <= 1'b0;
         req_word <= junk;
         repeat (n) @(posedge clock);
      end
   endtask

   // bursts of back-to-back words with random gaps, some long unbroken stretches
   task automatic pace();
      if (burst_left == 0) begin
         if ($urandom_range(0, 9) < 2) begin
            burst_left = $urandom_range(20, 40);
         end else begin
            idle($urandom_range(1, 12));
            burst_left = $urandom_range(1, 8);
         end
      end
      burst_left--;
   endtask

   // wait until every expected word has come, bounded in case some never do
   task automatic drain();
      int waited;
      waited = 0;
      start <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
      end while (sb.duty_queue.size() > 0 && waited < 4 * SERVICE_CYCLES);
   endtask

   task automatic program_regs(input logic [LEN_W-1:0] len, input logic [DUTY_W-1:0] pk,
                               input logic [LEN_W-1:0] ch);
      drain();
      // a silent service walk may still be running
      repeat (SERVICE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_PULSE_LEN;
      csr_wdata <= CSR_DATA_W'(len);
      @(posedge clock);
      csr_index <= CSR_PEAK_DUTY;
      csr_wdata <= CSR_DATA_W'(pk);
      @(posedge clock);
      csr_index <= CSR_BURST_CHNK;
      csr_wdata <= CSR_DATA_W'(ch);
      @(posedge clock);
      csr_we <= 1'b0;
      settings++;
   endtask

   // mostly well-formed commands, a few with out-of-range pads or odd codes
   function automatic req_word_type random_word();
      req_word_type w;
      int pick;
      pick           = $urandom_range(0, 99);
      w.pad_index    = PAD_W'($urandom);
      w.pattern_code = CODE_W'($urandom);
      if (pick < 42) begin
         w.req_type = REQ_TICK;
      end else if (pick < 66) begin
         w.req_type = REQ_SERVICE;
      end else if (pick < 84) begin
         w.req_type  = REQ_START;
         w.pad_index = PAD_W'($urandom_range(0, NUM_PADS - 1));
         if ($urandom_range(0, 3) != 0)
            w.pattern_code = CODE_W'($urandom_range(PAT_PULSE, PAT_BURST));
      end else if (pick < 94) begin
         w.req_type  = REQ_STOP;
         w.pad_index = PAD_W'($urandom_range(0, NUM_PADS - 1));
      end else begin
         w.req_type  = ($urandom_range(0, 1) != 0) ? REQ_START : REQ_STOP;
         w.pad_index = PAD_W'($urandom_range(NUM_PADS, (1 << PAD_W) - 1));
      end
      return w;
   endfunction

   task automatic run_phase(input int n);
      req_word_type w;
      int done;
      bit paused;
      done   = 0;
      paused = 1'b0;
      while (done < n) begin
         w = random_word();
         pace();
         send_word(w);
         if (!((w.req_type == REQ_START || w.req_type == REQ_STOP) &&
               w.pad_index >= NUM_PADS)) done++;
         // hold off once mid-phase until the block has answered everything
         if (!paused && done >= n / 2) begin
            drain();
            paused = 1'b1;
         end
      end
   endtask

   // directed words under reset registers, then a fast-expiring setting
   task automatic directed();
      send_word(make_word(REQ_SERVICE, 0, 0));
      send_word(make_word(REQ_STOP, 1, 0));
      send_word(make_word(REQ_START, 0, PAT_PULSE));
      send_word(make_word(REQ_START, 1, PAT_RAMP));
      send_word(make_word(REQ_START, 2, PAT_BURST));
      send_word(make_word(REQ_TICK, 7, 255));
      send_word(make_word(REQ_TICK, 0, 0));
      send_word(make_word(REQ_TICK, 5, 170));
      send_word(make_word(REQ_SERVICE, 7, 255));
      send_word(make_word(REQ_START, 7, 0));
      send_word(make_word(REQ_STOP, 7, 255));
      send_word(make_word(REQ_START, 0, 0));
      send_word(make_word(REQ_START, 1, 255));
      send_word(make_word(REQ_TICK, 0, 0));
      send_word(make_word(REQ_SERVICE, 0, 0));
      send_word(make_word(REQ_STOP, 2, 0));
      send_word(make_word(REQ_SERVICE, 0, 0));
      program_regs(16'd2, 8'd200, 16'd1);
      send_word(make_word(REQ_START, 0, PAT_RAMP));
      send_word(make_word(REQ_START, 1, PAT_BURST));
      send_word(make_word(REQ_START, 2, PAT_PULSE));
      send_word(make_word(REQ_SERVICE, 0, 0));
      send_word(make_word(REQ_TICK, 0, 0));
      send_word(make_word(REQ_SERVICE, 0, 0));
      send_word(make_word(REQ_TICK, 0, 0));
      send_word(make_word(REQ_SERVICE, 0, 0));
      send_word(make_word(REQ_SERVICE, 0, 0));
   endtask

   // run watchdog
   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("timeout after %0d cycles", LIMIT_CYCLES);
      $display("multi_channel_haptic_pattern_generator_unit_test failed");
      $finish;
   end

   initial begin
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      directed();
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: program_regs(16'hFFFF, 8'd255, 16'hFFFF);
            1: program_regs(16'd2, 8'd0, 16'd1);
            2: program_regs(LEN_W'($urandom_range(8, 40)), DUTY_W'($urandom_range(0, 255)),
                            LEN_W'($urandom_range(1, 8)));
            3: program_regs(LEN_W'($urandom_range(40, 120)), DUTY_W'($urandom_range(1, 255)),
                            LEN_W'($urandom_range(2, 20)));
            // shorter length while long ramps still run
            4: program_regs(16'd4, DUTY_W'($urandom_range(0, 255)),
                            LEN_W'($urandom_range(1, 3)));
            default: program_regs(PULSE_LEN_RST, PEAK_DUTY_RST, BURST_CHUNK_RST);
         endcase
         run_phase(RANDOM_WORDS / PHASES + 1);
      end
      drain();
      repeat (SERVICE_CYCLES) @(posedge clock);
      if (sb.duty_queue.size() != 0)
         sb.report_mismatch($sformatf("%0d expected words never came", sb.duty_queue.size()));
      $display("covered %0d ticks, %0d starts, %0d stops, %0d services, %0d out-of-range pads",
               sb.n_tick, sb.n_start, sb.n_stop, sb.n_service, sb.n_ignored);
      $display("checked %0d duty words over %0d register settings, %0d mismatches",
               sb.checked, settings, sb.errors);
      if (sb.errors == 0) begin
         $display("multi_channel_haptic_pattern_generator_unit_test passed");
      end else begin
         $display("multi_channel_haptic_pattern_generator_unit_test failed");
      end
      $finish;
   end

endmodule
